// File: rtl/core/searchable_fifo_queue_macros.svh
// Assertion macros shared by the searchable FIFO queue RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SEARCHABLE_FIFO_QUEUE_MACROS_SVH
`define SEARCHABLE_FIFO_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SFQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sfq_pkg.sv
// Shared types and constants for the searchable FIFO queue.
// No dependencies; used by sfq_cmp, sfq_seq and the top level in rtl/core.
package sfq_pkg;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int DATA_OUT_W = 32;
    localparam int CNT_OUT_W = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_COUNT  = 3'd4,
        OP_MAX    = 3'd5,
        OP_MIN    = 3'd6,
        OP_CLEAR  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // register index 0 in the APB map
    localparam logic REG_SIGNED_COMPARE = 1'b0;

    typedef struct packed {
        logic eq;
        logic gt;
        logic lt;
    } cmp_res_t;

    // lowest bits first: data_out, found, match_count, status, queue_size
    typedef struct packed {
        logic [CNT_OUT_W-1:0]  queue_size;
        status_t               status;
        logic [CNT_OUT_W-1:0]  match_count;
        logic                  found;
        logic [DATA_OUT_W-1:0] data_out;
    } result_t;

endpackage

// File: rtl/core/sfq_mem.sv
// Entry store: one write port, one read port with registered read data.
// No dependencies.
module sfq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sfq_cmp.sv
// Shared compare unit: equality plus signed or unsigned ordering.
// Depends on sfq_pkg (cmp_res_t).
module sfq_cmp #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sgn,
    output sfq_pkg::cmp_res_t res
);

    logic [WIDTH-1:0] flip;
    logic [WIDTH-1:0] key_a;
    logic [WIDTH-1:0] key_b;

    // flipping the sign bit turns signed order into unsigned order
    assign flip  = WIDTH'(sgn) << (WIDTH - 1);
    assign key_a = a ^ flip;
    assign key_b = b ^ flip;

    assign res.eq = (a == b);
    assign res.gt = (key_a > key_b);
    assign res.lt = (key_a < key_b);

endmodule

// File: rtl/core/sfq_seq.sv
// Sequencer for the searchable FIFO queue: ring pointers, scan and shift
// walks, result register. Depends on sfq_pkg and the macros header.
`include "searchable_fifo_queue_macros.svh"

module sfq_seq #(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sfq_pkg::op_t          s_mode,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  mem_we,
    output logic [IDX_W-1:0]      mem_waddr,
    output logic [VALUE_BITS-1:0] mem_wdata,
    output logic [IDX_W-1:0]      mem_raddr,
    input  logic [VALUE_BITS-1:0] mem_rdata,
    output logic [VALUE_BITS-1:0] cmp_b,
    input  sfq_pkg::cmp_res_t     cmp_res,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sfq_pkg::result_t      m_res
);

    sfq_pkg::state_t  state_reg, state_next;
    sfq_pkg::op_t     op_reg, op_next;
    sfq_pkg::status_t status_reg, status_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0] cmp_pos_reg, cmp_pos_next;
    logic [IDX_W-1:0] match_slot_reg, match_slot_next;
    logic [CNT_W-1:0] match_pos_reg, match_pos_next;
    logic             found_reg, found_next;
    logic             first_reg, first_next;
    logic [CNT_W-1:0] matches_reg, matches_next;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             out_valid_reg, out_valid_next;
    sfq_pkg::result_t out_reg, out_next;

    logic                  s_fire;
    logic                  walk_end;
    logic                  out_free;
    logic [IDX_W:0]        enq_sum;
    logic [IDX_W-1:0]      enq_slot;
    logic [VALUE_BITS+31:0] data_wide;
    logic [CNT_W+6:0]      size_wide;
    logic [CNT_W+6:0]      match_wide;
    logic                  is_pick;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(ENTRIES - 1)) begin
            r = '0;
        end else begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

    assign s_fire   = s_valid && s_ready;
    assign walk_end = (left_reg == '0) && !pend_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign is_pick  = (op_reg == sfq_pkg::OP_DEQ) || (op_reg == sfq_pkg::OP_MAX) ||
                      (op_reg == sfq_pkg::OP_MIN);

    // tail slot = head + count, wrapped
    assign enq_sum  = (IDX_W + 1)'(head_reg) + (IDX_W + 1)'(count_reg);
    assign enq_slot = (enq_sum >= (IDX_W + 1)'(ENTRIES)) ?
                      IDX_W'(enq_sum - (IDX_W + 1)'(ENTRIES)) : enq_sum[IDX_W-1:0];

    assign data_wide  = {32'b0, best_reg};
    assign size_wide  = {7'b0, count_reg};
    assign match_wide = {7'b0, matches_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfq_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (s_mode == sfq_pkg::OP_ENQ || s_mode == sfq_pkg::OP_CLEAR ||
                        count_reg == '0) begin
                        state_next = sfq_pkg::S_DONE;
                    end else begin
                        state_next = sfq_pkg::S_SCAN;
                    end
                end
            end
            sfq_pkg::S_SCAN: begin
                if (walk_end) begin
                    if (op_reg == sfq_pkg::OP_REMOVE && found_reg &&
                        (match_pos_reg + CNT_W'(1)) < count_reg) begin
                        state_next = sfq_pkg::S_SHIFT;
                    end else begin
                        state_next = sfq_pkg::S_DONE;
                    end
                end
            end
            sfq_pkg::S_SHIFT: begin
                if (walk_end) begin
                    state_next = sfq_pkg::S_DONE;
                end
            end
            sfq_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = sfq_pkg::S_IDLE;
                end
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        op_next         = op_reg;
        status_next     = status_reg;
        val_next        = val_reg;
        best_next       = best_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        pend_next       = 1'b0;
        rd_slot_next    = rd_slot_reg;
        cmp_pos_next    = cmp_pos_reg;
        match_slot_next = match_slot_reg;
        match_pos_next  = match_pos_reg;
        found_next      = found_reg;
        first_next      = first_reg;
        matches_next    = matches_reg;
        wr_ptr_next     = wr_ptr_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = ptr_reg;
        cmp_b           = is_pick ? best_reg : val_reg;
        s_ready         = (state_reg == sfq_pkg::S_IDLE);

        unique case (state_reg)
            sfq_pkg::S_IDLE: begin
                if (s_fire) begin
                    op_next      = s_mode;
                    val_next     = s_value;
                    status_next  = sfq_pkg::ST_OK;
                    found_next   = 1'b0;
                    first_next   = 1'b1;
                    matches_next = '0;
                    cmp_pos_next = '0;
                    ptr_next     = head_reg;
                    left_next    = count_reg;
                    unique case (s_mode)
                        sfq_pkg::OP_ENQ: begin
                            if (count_reg == CNT_W'(ENTRIES)) begin
                                status_next = sfq_pkg::ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = enq_slot;
                                mem_wdata  = s_value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        sfq_pkg::OP_CLEAR: begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        sfq_pkg::OP_DEQ: begin
                            // a one-entry pick walk reads the head
                            if (count_reg == '0) begin
                                status_next = sfq_pkg::ST_EMPTY;
                            end else begin
                                left_next = CNT_W'(1);
                            end
                        end
                        sfq_pkg::OP_REMOVE, sfq_pkg::OP_MAX, sfq_pkg::OP_MIN: begin
                            if (count_reg == '0) begin
                                status_next = sfq_pkg::ST_EMPTY;
                            end
                        end
                        sfq_pkg::OP_SEARCH, sfq_pkg::OP_COUNT: begin
                        end
                    endcase
                end
            end

            sfq_pkg::S_SCAN: begin
                if (left_reg != '0) begin
                    ptr_next     = wrap_inc(ptr_reg);
                    left_next    = left_reg - CNT_W'(1);
                    pend_next    = 1'b1;
                    rd_slot_next = ptr_reg;
                end
                if (pend_reg) begin
                    cmp_pos_next = cmp_pos_reg + CNT_W'(1);
                    unique case (op_reg)
                        sfq_pkg::OP_REMOVE, sfq_pkg::OP_SEARCH: begin
                            if (cmp_res.eq && !found_reg) begin
                                found_next      = 1'b1;
                                match_slot_next = rd_slot_reg;
                                match_pos_next  = cmp_pos_reg;
                            end
                        end
                        sfq_pkg::OP_COUNT: begin
                            if (cmp_res.eq) begin
                                matches_next = matches_reg + CNT_W'(1);
                            end
                        end
                        sfq_pkg::OP_DEQ, sfq_pkg::OP_MAX, sfq_pkg::OP_MIN: begin
                            // strict compare keeps the oldest of equal values
                            if (first_reg || (op_reg == sfq_pkg::OP_MAX && cmp_res.gt) ||
                                (op_reg == sfq_pkg::OP_MIN && cmp_res.lt)) begin
                                best_next  = mem_rdata;
                                first_next = 1'b0;
                            end
                        end
                        sfq_pkg::OP_ENQ, sfq_pkg::OP_CLEAR: begin
                        end
                    endcase
                end
                if (walk_end) begin
                    if (op_reg == sfq_pkg::OP_DEQ) begin
                        head_next  = wrap_inc(head_reg);
                        count_next = count_reg - CNT_W'(1);
                    end else if (op_reg == sfq_pkg::OP_REMOVE) begin
                        if (!found_reg) begin
                            status_next = sfq_pkg::ST_NOTFOUND;
                        end else if ((match_pos_reg + CNT_W'(1)) < count_reg) begin
                            // close the gap: entry k+1 moves to k, up to the tail
                            wr_ptr_next = match_slot_reg;
                            ptr_next    = wrap_inc(match_slot_reg);
                            left_next   = count_reg - CNT_W'(1) - match_pos_reg;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end

            sfq_pkg::S_SHIFT: begin
                if (left_reg != '0) begin
                    ptr_next  = wrap_inc(ptr_reg);
                    left_next = left_reg - CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    mem_we      = 1'b1;
                    wr_ptr_next = wrap_inc(wr_ptr_reg);
                end
                if (walk_end) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end

            sfq_pkg::S_DONE: begin
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_next.data_out    = (is_pick && status_reg == sfq_pkg::ST_OK) ?
                                           data_wide[sfq_pkg::DATA_OUT_W-1:0] : '0;
                    out_next.found       = found_reg;
                    out_next.match_count = match_wide[sfq_pkg::CNT_OUT_W-1:0];
                    out_next.status      = status_reg;
                    out_next.queue_size  = size_wide[sfq_pkg::CNT_OUT_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sfq_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        val_reg        <= val_next;
        best_reg       <= best_next;
        ptr_reg        <= ptr_next;
        left_reg       <= left_next;
        rd_slot_reg    <= rd_slot_next;
        cmp_pos_reg    <= cmp_pos_next;
        match_slot_reg <= match_slot_next;
        match_pos_reg  <= match_pos_next;
        found_reg      <= found_next;
        first_reg      <= first_next;
        matches_reg    <= matches_next;
        wr_ptr_reg     <= wr_ptr_next;
        out_reg        <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    `SFQ_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(ENTRIES), "entry count exceeds depth")
    `SFQ_ASSERT_NOW(a_head_bound, aclk, aresetn, 1'b1, head_reg <= IDX_W'(ENTRIES - 1), "head position out of ring")
    `SFQ_ASSERT_NEXT(a_clear_empties, aclk, aresetn, s_fire && s_mode == sfq_pkg::OP_CLEAR, count_reg == '0 && head_reg == '0, "clear left entries behind")
    `SFQ_ASSERT_NEXT(a_enq_grows, aclk, aresetn, s_fire && s_mode == sfq_pkg::OP_ENQ && count_reg != CNT_W'(ENTRIES), count_reg == $past(count_reg) + CNT_W'(1), "enqueue did not grow queue")

endmodule

// File: rtl/core/searchable_fifo_queue.sv
// Top level of the searchable FIFO queue: APB config register, port packing.
// Depends on sfq_pkg, sfq_mem, sfq_cmp, sfq_seq.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser: mode, s_tdata: value
//  m_      | out | m_tvalid/m_tready  | m_tdata: data_out, found, match_count,
//          |     |                    |          status, queue_size
//  apb     | in  | psel/penable/pready| register 0 signed_compare at byte 0
//
// Enqueue, clear and any op on an empty queue skip the walk; dequeue walks
// the head entry only; search, count, largest and smallest walk all n entries
// held; remove walks them all, then shifts the entries behind a match at k.
// The walk reads the entry memory one entry per cycle through its single read
// port; the shared compare unit checks each entry as it arrives.
// Reset (aresetn low, synchronous) empties the queue and clears signed_compare;
// the entry memory is not cleared and needs no sweep.
// A stalled result sits in the output register; the next word is accepted and
// worked on meanwhile, and only waits at completion for the register to free.
module searchable_fifo_queue #(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfq_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] value
    input  logic [sfq_pkg::S_TUSER_W-1:0]    s_tuser,   // [2:0] mode
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] data_out, [32] found, [39:33] match_count, [41:40] status,
    // [48:42] queue_size, [55:49] zero
    output logic [sfq_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sfq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sfq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                    signed_compare_reg, signed_compare_next;
    logic                    reg_hit;
    logic [VALUE_BITS+31:0]  value_wide;
    logic [VALUE_BITS-1:0]   value_vb;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [VALUE_BITS-1:0]   mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic [VALUE_BITS-1:0]   mem_rdata;
    logic [VALUE_BITS-1:0]   cmp_b;
    sfq_pkg::cmp_res_t       cmp_res;
    sfq_pkg::result_t        res;

    // APB: one register, decoded on the word index bit; pready tied high
    assign pready  = 1'b1;
    assign reg_hit = (paddr[sfq_pkg::APB_ADDR_W-1] == sfq_pkg::REG_SIGNED_COMPARE);

    always_comb begin
        signed_compare_next = signed_compare_reg;
        if (psel && penable && pwrite && reg_hit) begin
            signed_compare_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_compare_reg <= 1'b0;
        end else begin
            signed_compare_reg <= signed_compare_next;
        end
    end

    assign prdata = reg_hit ? {{(sfq_pkg::APB_DATA_W - 1){1'b0}}, signed_compare_reg} : '0;

    // value taken in its low VALUE_BITS bits, zero-extended above 32
    assign value_wide = {VALUE_BITS'(0), s_tdata};
    assign value_vb   = value_wide[VALUE_BITS-1:0];

    sfq_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sfq_cmp #(
        .WIDTH (VALUE_BITS)
    ) u_cmp (
        .a   (mem_rdata),
        .b   (cmp_b),
        .sgn (signed_compare_reg),
        .res (cmp_res)
    );

    sfq_seq #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_mode    (sfq_pkg::op_t'(s_tuser)),
        .s_value   (value_vb),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .cmp_b     (cmp_b),
        .cmp_res   (cmp_res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res)
    );

    assign m_tdata = {{(sfq_pkg::M_TDATA_W - $bits(sfq_pkg::result_t)){1'b0}}, res};

endmodule
